// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/kdrq_pkg.sv
// ----------------------------------------------------------------------------
// kdrq_pkg
// Types and constants for the key debounce, repeat and quadrature unit.
// ----------------------------------------------------------------------------
package kdrq_pkg;

    localparam int NUM_KEYS = 2;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SAMPLE_DIVIDER = 2'd0,
        REG_REPEAT_START   = 2'd1,
        REG_REPEAT_NEXT    = 2'd2,
        REG_REPEAT_KEYS    = 2'd3
    } cfg_reg_t;

    // Encoder take modes
    typedef enum logic [1:0] {
        TAKE_NONE  = 2'd0,
        TAKE_ALL   = 2'd1,
        TAKE_PAIRS = 2'd2,
        TAKE_QUADS = 2'd3
    } take_mode_t;

    // Reset values of the configuration registers
    localparam logic [7:0]          SAMPLE_DIVIDER_RST = 8'd10;
    localparam logic [7:0]          REPEAT_START_RST   = 8'd50;
    localparam logic [7:0]          REPEAT_NEXT_RST    = 8'd20;
    localparam logic [NUM_KEYS-1:0] REPEAT_KEYS_RST    = NUM_KEYS'(1);

    typedef struct packed {
        logic [NUM_KEYS-1:0] raw_keys_low;
        logic                phase_a;
        logic                phase_b;
        logic [NUM_KEYS-1:0] press_ack_mask;
        logic [NUM_KEYS-1:0] repeat_ack_mask;
        logic [1:0]          encoder_take;
    } kdrq_in_t;

    typedef struct packed {
        logic [NUM_KEYS-1:0] debounced_keys;
        logic [NUM_KEYS-1:0] press_taken;
        logic [NUM_KEYS-1:0] repeat_taken;
        logic signed [7:0]   encoder_steps;
    } kdrq_out_t;

endpackage

// File: hdl/key_debounce_repeat_quadrature_unit.sv
// ----------------------------------------------------------------------------
// key_debounce_repeat_quadrature_unit
// Two-key vertical-counter debouncer with auto-repeat flags and a
// quadrature step accumulator, one timer tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one timer tick per request: raw active-low
//   key levels, encoder phases, press and repeat acknowledges and an encoder
//   take. out_valid/out_ready/out_data return exactly one result per tick.
//   cfg_we/cfg_index/cfg_data write the divider and repeat registers; write
//   them only while no request is in flight.
//   Latency: a result is shown the cycle after its request is accepted.
//   Throughput: one request per clock, set by the single result register;
//   the whole tick update is one pass of logic on the state registers.
//   When the receiver stalls, the result register holds and in_ready drops
//   until the result is taken; in_ready stays high while out_ready is high.
//   Reset (rst_n low, asynchronous) restores the register defaults
//   (divider 10, repeat start 50, repeat next 20, repeat mask key zero),
//   clears the flags, accumulator and tick counter, sets the vertical
//   counters to all ones and loads the repeat countdown with 50.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_debounce_repeat_quadrature_unit
    import kdrq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  kdrq_in_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kdrq_out_t           out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    // Configuration registers
    logic [7:0]          sample_divider_reg;
    logic [7:0]          repeat_start_reg;
    logic [7:0]          repeat_next_reg;
    logic [NUM_KEYS-1:0] repeat_keys_reg;

    // Tick state
    logic [NUM_KEYS-1:0] debounced_reg,  debounced_next;
    logic [NUM_KEYS-1:0] vcount_low_reg, vcount_low_next;
    logic [NUM_KEYS-1:0] vcount_high_reg, vcount_high_next;
    logic [NUM_KEYS-1:0] press_flags_reg, press_flags_next;
    logic [NUM_KEYS-1:0] repeat_flags_reg, repeat_flags_next;
    logic [7:0]          countdown_reg,  countdown_next;
    logic [7:0]          tick_count_reg, tick_count_next;
    logic [1:0]          last_phase_reg, last_phase_next;
    logic [7:0]          step_accum_reg, step_accum_next;

    // Result register
    logic                out_valid_reg;
    kdrq_out_t           out_data_reg,   out_data_next;

    logic                accept;

    // Intermediate terms of the tick update
    logic [NUM_KEYS-1:0] press_taken;
    logic [NUM_KEYS-1:0] repeat_taken;
    logic [NUM_KEYS-1:0] press_kept;
    logic [NUM_KEYS-1:0] repeat_kept;
    logic [NUM_KEYS-1:0] change_raw;
    logic [NUM_KEYS-1:0] change_ok;
    logic [NUM_KEYS-1:0] vl_new;
    logic [NUM_KEYS-1:0] vh_new;
    logic [NUM_KEYS-1:0] deb_new;
    logic [NUM_KEYS-1:0] held_rpt;
    logic [7:0]          cd_load;
    logic [7:0]          cd_dec;
    logic [7:0]          accum_kept;
    logic signed [7:0]   steps_out;
    logic [7:0]          div_eff;
    logic [7:0]          tick_inc;
    logic [1:0]          pos;
    logic [1:0]          phase_diff;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Acknowledges and encoder take see the state from before the tick
    always_comb
    begin
        press_taken  = in_data.press_ack_mask & press_flags_reg;
        press_kept   = press_flags_reg ^ press_taken;
        repeat_taken = in_data.repeat_ack_mask & repeat_flags_reg;
        repeat_kept  = repeat_flags_reg ^ repeat_taken;

        case (take_mode_t'(in_data.encoder_take))
            TAKE_ALL:
            begin
                steps_out  = $signed(step_accum_reg);
                accum_kept = 8'd0;
            end
            TAKE_PAIRS:
            begin
                steps_out  = $signed(step_accum_reg) >>> 1;
                accum_kept = {7'd0, step_accum_reg[0]};
            end
            TAKE_QUADS:
            begin
                steps_out  = $signed(step_accum_reg) >>> 2;
                accum_kept = {6'd0, step_accum_reg[1:0]};
            end
            default:
            begin
                steps_out  = 8'sd0;
                accum_kept = step_accum_reg;
            end
        endcase
    end

    // Vertical-counter debounce and repeat countdown for one sample
    always_comb
    begin
        change_raw = debounced_reg ^ ~in_data.raw_keys_low;
        vl_new     = ~(vcount_low_reg & change_raw);
        vh_new     = vl_new ^ (vcount_high_reg & change_raw);
        change_ok  = change_raw & vl_new & vh_new;
        deb_new    = debounced_reg ^ change_ok;
        held_rpt   = deb_new & repeat_keys_reg;
        cd_load    = (held_rpt == '0) ? repeat_start_reg : countdown_reg;
        cd_dec     = cd_load - 8'd1;
    end

    // Tick divider and quadrature decode
    always_comb
    begin
        div_eff    = (sample_divider_reg == 8'd0) ? 8'd1 : sample_divider_reg;
        tick_inc   = tick_count_reg + 8'd1;
        pos        = {in_data.phase_a, in_data.phase_a ^ in_data.phase_b};
        phase_diff = last_phase_reg - pos;
    end

    // Next state of the tick
    always_comb
    begin
        debounced_next    = debounced_reg;
        vcount_low_next   = vcount_low_reg;
        vcount_high_next  = vcount_high_reg;
        press_flags_next  = press_kept;
        repeat_flags_next = repeat_kept;
        countdown_next    = countdown_reg;
        last_phase_next   = last_phase_reg;
        step_accum_next   = accum_kept;

        if (tick_count_reg == 8'd0)
        begin
            debounced_next   = deb_new;
            vcount_low_next  = vl_new;
            vcount_high_next = vh_new;
            press_flags_next = press_kept | (deb_new & change_ok);
            if (cd_dec == 8'd0)
            begin
                countdown_next    = repeat_next_reg;
                repeat_flags_next = repeat_kept | held_rpt;
            end
            else
            begin
                countdown_next = cd_dec;
            end
        end

        tick_count_next = (tick_inc >= div_eff) ? 8'd0 : tick_inc;

        // Single-step changes only; a double step is ignored
        if (phase_diff[0])
        begin
            last_phase_next = pos;
            step_accum_next = phase_diff[1] ? accum_kept + 8'd1 : accum_kept - 8'd1;
        end

        out_data_next.debounced_keys = debounced_next;
        out_data_next.press_taken    = press_taken;
        out_data_next.repeat_taken   = repeat_taken;
        out_data_next.encoder_steps  = steps_out;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_divider_reg <= SAMPLE_DIVIDER_RST;
            repeat_start_reg   <= REPEAT_START_RST;
            repeat_next_reg    <= REPEAT_NEXT_RST;
            repeat_keys_reg    <= REPEAT_KEYS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SAMPLE_DIVIDER: sample_divider_reg <= cfg_data;
                REG_REPEAT_START:   repeat_start_reg   <= cfg_data;
                REG_REPEAT_NEXT:    repeat_next_reg    <= cfg_data;
                REG_REPEAT_KEYS:    repeat_keys_reg    <= cfg_data[NUM_KEYS-1:0];
                default:            ;
            endcase
        end
    end

    // Tick state, updated on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounced_reg    <= '0;
            vcount_low_reg   <= '1;
            vcount_high_reg  <= '1;
            press_flags_reg  <= '0;
            repeat_flags_reg <= '0;
            countdown_reg    <= REPEAT_START_RST;
            tick_count_reg   <= 8'd0;
            last_phase_reg   <= 2'd0;
            step_accum_reg   <= 8'd0;
        end
        else if (accept)
        begin
            debounced_reg    <= debounced_next;
            vcount_low_reg   <= vcount_low_next;
            vcount_high_reg  <= vcount_high_next;
            press_flags_reg  <= press_flags_next;
            repeat_flags_reg <= repeat_flags_next;
            countdown_reg    <= countdown_next;
            tick_count_reg   <= tick_count_next;
            last_phase_reg   <= last_phase_next;
            step_accum_reg   <= step_accum_next;
        end
    end

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    // Checks
    `ASSERT_IMPLIES(a_stall_blocks, clk, rst_n, out_valid && !out_ready, !in_ready, "request taken while result stalled")
    `ASSERT_NEXT(a_accept_result, clk, rst_n, accept, out_valid, "accepted request gave no result")
    `ASSERT_NEXT(a_press_subset, clk, rst_n, accept, (out_data.press_taken & ~$past(press_flags_reg)) == '0, "press returned that was not pending")
    `ASSERT_NEXT(a_no_take_zero, clk, rst_n, accept && (in_data.encoder_take == TAKE_NONE), out_data.encoder_steps == 8'sd0, "steps returned without a take")
    `ASSERT_IMPLIES(a_toggle_full, clk, rst_n, debounced_reg != $past(debounced_reg), ((debounced_reg ^ $past(debounced_reg)) & ~(vcount_low_reg & vcount_high_reg)) == '0, "key toggled before counter was full")

endmodule

// File: tb/key_debounce_repeat_quadrature_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_repeat_quadrature_unit_tb
// Drives timer ticks into the key debounce, repeat and quadrature unit and
// checks every result against a cycle-free prediction of the tick update.
// A short directed sequence covers debounce, acknowledges, the take modes and
// phase jumps; random phases follow under several register settings, with
// bursts of idling on both handshakes.
// ----------------------------------------------------------------------------
module key_debounce_repeat_quadrature_unit_tb;

    import kdrq_pkg::*;

    // Prediction of the tick update plus the queue of results still due
    class tick_tracker;
        logic [7:0]          sample_div;
        logic [7:0]          rep_start;
        logic [7:0]          rep_next;
        logic [NUM_KEYS-1:0] rep_mask;
        logic [NUM_KEYS-1:0] deb;
        logic [NUM_KEYS-1:0] vc_lo;
        logic [NUM_KEYS-1:0] vc_hi;
        logic [NUM_KEYS-1:0] press;
        logic [NUM_KEYS-1:0] rpt;
        logic [7:0]          countdown;
        logic [7:0]          ticks;
        logic [1:0]          last_pos;
        logic signed [7:0]   accum;
        kdrq_out_t           due_results[$];
        int                  fails;

        function new();
            sample_div = SAMPLE_DIVIDER_RST;
            rep_start  = REPEAT_START_RST;
            rep_next   = REPEAT_NEXT_RST;
            rep_mask   = REPEAT_KEYS_RST;
            deb        = '0;
            vc_lo      = '1;
            vc_hi      = '1;
            press      = '0;
            rpt        = '0;
            countdown  = REPEAT_START_RST;
            ticks      = '0;
            last_pos   = '0;
            accum      = '0;
            fails      = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [7:0] val);
            case (idx)
                REG_SAMPLE_DIVIDER: sample_div = val;
                REG_REPEAT_START:   rep_start  = val;
                REG_REPEAT_NEXT:    rep_next   = val;
                REG_REPEAT_KEYS:    rep_mask   = val[NUM_KEYS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // One accepted tick: acknowledges and take first, then sampling
        function void note_tick(kdrq_in_t t);
            kdrq_out_t           res;
            logic [NUM_KEYS-1:0] change;
            logic [7:0]          div;
            logic [1:0]          pos;
            logic [1:0]          d;

            res = '0;
            res.press_taken = t.press_ack_mask & press;
            press ^= res.press_taken;
            res.repeat_taken = t.repeat_ack_mask & rpt;
            rpt ^= res.repeat_taken;

            case (take_mode_t'(t.encoder_take))
                TAKE_ALL:
                begin
                    res.encoder_steps = accum;
                    accum = '0;
                end
                TAKE_PAIRS:
                begin
                    res.encoder_steps = accum >>> 1;
                    accum = accum & 8'sd1;
                end
                TAKE_QUADS:
                begin
                    res.encoder_steps = accum >>> 2;
                    accum = accum & 8'sd3;
                end
                default: res.encoder_steps = '0;
            endcase

            // vertical counter debounce and auto-repeat, on sample ticks only
            if (ticks == 8'd0)
            begin
                change = deb ^ ~t.raw_keys_low;
                vc_lo  = ~(vc_lo & change);
                vc_hi  = vc_lo ^ (vc_hi & change);
                change &= vc_lo & vc_hi;
                deb    ^= change;
                press  |= deb & change;
                if ((deb & rep_mask) == '0)
                    countdown = rep_start;
                countdown = countdown - 8'd1;
                if (countdown == 8'd0)
                begin
                    countdown = rep_next;
                    rpt |= deb & rep_mask;
                end
            end
            div   = (sample_div == 8'd0) ? 8'd1 : sample_div;
            ticks = ticks + 8'd1;
            if (ticks >= div)
                ticks = 8'd0;

            // Gray position; a jump of two positions is dropped
            pos = {t.phase_a, t.phase_a ^ t.phase_b};
            d   = last_pos - pos;
            if (d[0])
            begin
                last_pos = pos;
                accum    = d[1] ? accum + 8'sd1 : accum - 8'sd1;
            end

            res.debounced_keys = deb;
            due_results.push_back(res);
        endfunction

        task report(string what, logic [15:0] got_v, logic [15:0] want_v);
            $display("%0t  mismatch %s: got %h, want %h", $time, what, got_v, want_v);
            fails++;
        endtask

        task check_result(kdrq_out_t got);
            kdrq_out_t want;
            if (due_results.size() == 0)
            begin
                report("result with no request outstanding", 16'(got), 16'h0);
                return;
            end
            want = due_results.pop_front();
            if (got.debounced_keys !== want.debounced_keys)
                report("debounced_keys", 16'(got.debounced_keys), 16'(want.debounced_keys));
            if (got.press_taken !== want.press_taken)
                report("press_taken", 16'(got.press_taken), 16'(want.press_taken));
            if (got.repeat_taken !== want.repeat_taken)
                report("repeat_taken", 16'(got.repeat_taken), 16'(want.repeat_taken));
            if (got.encoder_steps !== want.encoder_steps)
                report("encoder_steps", 16'(got.encoder_steps), 16'(want.encoder_steps));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    kdrq_in_t   in_data;
    logic       out_valid;
    logic       out_ready;
    kdrq_out_t  out_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    tick_tracker tracker = new();

    // stimulus state carried across phases
    bit                  idle_on  = 1'b1;
    logic [1:0]          enc_pos  = 2'd0;
    bit                  enc_fwd  = 1'b1;
    logic [NUM_KEYS-1:0] key_held = '0;

    key_debounce_repeat_quadrature_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result side: check every accepted result
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            tracker.check_result(out_data);

    // Result side: stall in bursts while idling is on
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Build one tick from an encoder position (0..3 around the Gray cycle)
    function automatic kdrq_in_t mk_tick(logic [1:0] raw, logic [1:0] pos,
                                         logic [1:0] pack, logic [1:0] rack,
                                         take_mode_t take);
        kdrq_in_t t;
        t.raw_keys_low    = raw;
        t.phase_a         = pos[1];
        t.phase_b         = pos[1] ^ pos[0];
        t.press_ack_mask  = pack;
        t.repeat_ack_mask = rack;
        t.encoder_take    = take;
        return t;
    endfunction

    // Offer one request, with an occasional idle burst in front of it
    task automatic send_tick(kdrq_in_t t);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        do @(posedge clk); while (!in_ready);
        tracker.note_tick(t);
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(cfg_reg_t idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    // All four registers back to back; only called with nothing in flight
    task automatic write_config(logic [7:0] div, logic [7:0] start,
                                logic [7:0] rep_gap, logic [1:0] keys);
        put_reg(REG_SAMPLE_DIVIDER, div);
        put_reg(REG_REPEAT_START, start);
        put_reg(REG_REPEAT_NEXT, rep_gap);
        put_reg(REG_REPEAT_KEYS, {6'b0, keys});
        cfg_we <= 1'b0;
    endtask

    // Debounce, flag acknowledges, every take mode and phase jumps
    task automatic run_directed();
        kdrq_in_t plan[$];
        // both keys held; press flags set on the fourth sample, with an ack
        // in the same tick that must not clear them
        plan.push_back(mk_tick(2'b00, 2'd0, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b00, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b00, 2'd2, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b00, 2'd3, 2'b11, 2'b11, TAKE_NONE));
        plan.push_back(mk_tick(2'b00, 2'd0, 2'b00, 2'b00, TAKE_ALL));
        plan.push_back(mk_tick(2'b00, 2'd3, 2'b11, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b00, 2'd2, 2'b00, 2'b11, TAKE_NONE));
        plan.push_back(mk_tick(2'b00, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b00, 2'd0, 2'b00, 2'b01, TAKE_NONE));
        // negative totals through the arithmetic shifts
        plan.push_back(mk_tick(2'b00, 2'd3, 2'b00, 2'b10, TAKE_QUADS));
        plan.push_back(mk_tick(2'b00, 2'd2, 2'b00, 2'b11, TAKE_PAIRS));
        // both phases flip at once: ignored
        plan.push_back(mk_tick(2'b00, 2'd0, 2'b00, 2'b00, TAKE_PAIRS));
        // release, with acks while the state settles
        plan.push_back(mk_tick(2'b11, 2'd0, 2'b11, 2'b11, TAKE_NONE));
        plan.push_back(mk_tick(2'b11, 2'd1, 2'b00, 2'b01, TAKE_ALL));
        plan.push_back(mk_tick(2'b11, 2'd1, 2'b00, 2'b10, TAKE_NONE));
        plan.push_back(mk_tick(2'b11, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b11, 2'd1, 2'b11, 2'b11, TAKE_NONE));
        // key zero alone, with a bounce that restarts the count
        plan.push_back(mk_tick(2'b10, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b10, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b01, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b10, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b10, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b10, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b10, 2'd1, 2'b00, 2'b00, TAKE_NONE));
        plan.push_back(mk_tick(2'b10, 2'd1, 2'b11, 2'b11, TAKE_NONE));
        foreach (plan[i])
            send_tick(plan[i]);
        enc_pos = 2'd1;
    endtask

    // Held keys with bounces, an encoder walk, sparse acks and takes.
    // A take_odds of 0 means one full take up front and a straight walk,
    // long enough to wrap the step total.
    task automatic run_random(int count, int take_odds);
        kdrq_in_t t;
        int       pick;
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
                if ($urandom_range(0, 19) == 0)
                    key_held[k] = ~key_held[k];
            t.raw_keys_low = ~key_held;
            if ($urandom_range(0, 9) == 0)
                t.raw_keys_low = NUM_KEYS'($urandom_range(0, 3));
            else if ($urandom_range(0, 7) == 0)
                t.raw_keys_low ^= NUM_KEYS'($urandom_range(1, 3));

            pick = $urandom_range(0, 15);
            if (take_odds == 0)
            begin
                if (pick < 14)
                    enc_pos = enc_fwd ? enc_pos + 2'd1 : enc_pos - 2'd1;
            end
            else
            begin
                if (pick == 0)
                    enc_fwd = ~enc_fwd;
                if (pick < 10)
                    enc_pos = enc_fwd ? enc_pos + 2'd1 : enc_pos - 2'd1;
                else if (pick == 10)
                    enc_pos = enc_pos + 2'd2;
            end
            t.phase_a = enc_pos[1];
            t.phase_b = enc_pos[1] ^ enc_pos[0];

            t.press_ack_mask  = ($urandom_range(0, 3) == 0) ?
                                NUM_KEYS'($urandom_range(0, 3)) : '0;
            t.repeat_ack_mask = ($urandom_range(0, 3) == 0) ?
                                NUM_KEYS'($urandom_range(0, 3)) : '0;
            if (take_odds == 0)
                t.encoder_take = (n == 0) ? TAKE_ALL : TAKE_NONE;
            else if ($urandom_range(0, take_odds) == 0)
                t.encoder_take = 2'($urandom_range(1, 3));
            else
                t.encoder_take = TAKE_NONE;
            send_tick(t);
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_SAMPLE_DIVIDER;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults straight after reset
        run_random(20, 8);
        wait_results_done();

        write_config(8'd1, 8'd3, 8'd2, 2'b11);
        run_directed();
        wait_results_done();

        // lowest settings
        write_config(8'd1, 8'd1, 8'd1, 2'b11);
        run_random(40, 6);
        wait_results_done();

        // highest settings
        write_config(8'd255, 8'd255, 8'd255, 2'b00);
        run_random(30, 6);
        wait_results_done();

        // zero divider and zero repeat loads; the divider drops under the count
        write_config(8'd0, 8'd0, 8'd0, 2'b10);
        run_random(40, 6);
        wait_results_done();

        write_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 8)),
                     8'($urandom_range(1, 5)), 2'($urandom_range(0, 3)));
        run_random(200, 0);
        wait_results_done();

        write_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 8)),
                     8'($urandom_range(1, 5)), 2'($urandom_range(0, 3)));
        run_random(40, 6);
        wait_results_done();

        // closing stretch at full rate
        idle_on = 1'b0;
        write_config(8'($urandom_range(1, 3)), 8'($urandom_range(1, 6)),
                     8'($urandom_range(1, 4)), 2'($urandom_range(0, 3)));
        run_random(30, 6);
        wait_results_done();

        repeat (5) @(posedge clk);
        if (tracker.fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
